/* rtl/hcpc_pkg.sv */
package hcpc_pkg;

  localparam int MAX_GENERATIONS = 16;
  localparam int PIXEL_BITS      = 8;
  localparam int RULE_W          = 64;
  localparam int GEN_W           = 5;
  localparam int CFG_IDX_W       = 2;
  localparam int CFG_DATA_W      = 64;

  typedef logic [PIXEL_BITS-1:0] pixel_t;
  typedef logic [RULE_W-1:0]     rules_t;

  // configuration register indexes
  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_RULE_CODES   = 2'd0,
    CFG_GENERATIONS  = 2'd1,
    CFG_DECRYPT_MODE = 2'd2
  } cfg_index_t;

  localparam rules_t              RULE_RESET = 64'h99F0_5633_6666_6666;
  localparam logic [GEN_W-1:0]    GEN_RESET  = 5'd4;
  localparam pixel_t              ENC_MULT   = 8'd187;
  localparam pixel_t              DEC_MULT   = 8'd115;

  localparam logic [7:0] RULE_51  = 8'd51;
  localparam logic [7:0] RULE_85  = 8'd85;
  localparam logic [7:0] RULE_86  = 8'd86;
  localparam logic [7:0] RULE_102 = 8'd102;
  localparam logic [7:0] RULE_105 = 8'd105;
  localparam logic [7:0] RULE_150 = 8'd150;
  localparam logic [7:0] RULE_153 = 8'd153;
  localparam logic [7:0] RULE_165 = 8'd165;
  localparam logic [7:0] RULE_240 = 8'd240;

  // per-cell control from the top level
  typedef struct packed {
    logic advance;
    logic active;
  } cell_ctl_t;

  function automatic logic rule_supported(input logic [7:0] code);
    logic ok;
    case (code)
      RULE_51, RULE_85, RULE_86, RULE_102, RULE_105,
      RULE_150, RULE_153, RULE_165, RULE_240: ok = 1'b1;
      default: ok = 1'b0;
    endcase
    return ok;
  endfunction

  // one generation, all automaton cells in parallel; bit 7 is cell 0
  function automatic pixel_t ca_generation(input pixel_t px, input rules_t rules);
    pixel_t                nxt;
    logic [PIXEL_BITS+1:0] padded;
    logic [7:0]            code;
    logic [2:0]            sel;
    nxt    = '0;
    // null neighbors at both ends
    padded = {1'b0, px, 1'b0};
    for (int k = 0; k < PIXEL_BITS; k++) begin
      code  = rules[8*k +: 8];
      sel   = padded[PIXEL_BITS - 1 - k +: 3];
      nxt[PIXEL_BITS - 1 - k] = rule_supported(code) ? code[sel] : 1'b0;
    end
    return nxt;
  endfunction

endpackage

/* rtl/hcpc_cell.sv */
module hcpc_cell (
  input  logic                clk,
  input  logic                rst,
  input  hcpc_pkg::cell_ctl_t ctl,
  input  hcpc_pkg::rules_t    rules,
  input  logic                valid_in,
  input  hcpc_pkg::pixel_t    px_in,
  output logic                valid_out,
  output hcpc_pkg::pixel_t    px_out
);

  logic             valid;
  hcpc_pkg::pixel_t px;
  hcpc_pkg::pixel_t px_next;

  // cells past the configured generation count just pass the pixel on
  assign px_next = ctl.active ? hcpc_pkg::ca_generation(px_in, rules) : px_in;

  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= 1'b0;
    end else if (ctl.advance) begin
      valid <= valid_in;
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.advance) begin
      px <= px_next;
    end
  end

  assign valid_out = valid;
  assign px_out    = px;

endmodule

/* rtl/hybrid_ca_pixel_cipher_core.sv */
// channel  | valid     | flow control     | payload
// ---------+-----------+------------------+----------------------------
// input    | in_valid  | in_stall (out)   | pixel_in
// output   | out_valid | out_stall (in)   | pixel_out
// config   | cfg_valid | cfg_ready (out)  | cfg_index, cfg_data
//
// one pixel per clock while out_stall does not hold the chain; a scaling
// stage, one automaton cell per generation, and the output scaling register.
// every pipeline stage moves together; out_stall with a valid output
// freezes the whole chain and raises in_stall in the same cycle.
// synchronous reset empties the chain and loads the default configuration.
module hybrid_ca_pixel_cipher_core (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                in_valid,
  output logic                                in_stall,
  input  logic [hcpc_pkg::PIXEL_BITS-1:0]     pixel_in,
  output logic                                out_valid,
  input  logic                                out_stall,
  output logic [hcpc_pkg::PIXEL_BITS-1:0]     pixel_out,
  input  logic                                cfg_valid,
  output logic                                cfg_ready,
  input  logic [hcpc_pkg::CFG_IDX_W-1:0]      cfg_index,
  input  logic [hcpc_pkg::CFG_DATA_W-1:0]     cfg_data
);

  localparam int NCELL = hcpc_pkg::MAX_GENERATIONS;

  hcpc_pkg::rules_t              rule_codes;
  logic [hcpc_pkg::GEN_W-1:0]    generations;
  logic                          decrypt_mode;

  logic                          advance;
  logic                          pre_valid;
  hcpc_pkg::pixel_t              pre_px;
  logic [NCELL:0]                chain_valid;
  hcpc_pkg::pixel_t              chain_px [NCELL+1];
  logic                          out_valid_r;
  hcpc_pkg::pixel_t              pixel_out_r;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      rule_codes   <= hcpc_pkg::RULE_RESET;
      generations  <= hcpc_pkg::GEN_RESET;
      decrypt_mode <= 1'b0;
    end else if (cfg_valid) begin
      case (hcpc_pkg::cfg_index_t'(cfg_index))
        hcpc_pkg::CFG_RULE_CODES:   rule_codes   <= cfg_data;
        hcpc_pkg::CFG_GENERATIONS:  generations  <= cfg_data[hcpc_pkg::GEN_W-1:0];
        hcpc_pkg::CFG_DECRYPT_MODE: decrypt_mode <= cfg_data[0];
        default: ;
      endcase
    end
  end

  assign advance  = !out_valid_r || !out_stall;
  assign in_stall = !advance;

  // decrypt scales before the automaton
  always_ff @(posedge clk) begin
    if (rst) begin
      pre_valid <= 1'b0;
    end else if (advance) begin
      pre_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      pre_px <= decrypt_mode ? hcpc_pkg::pixel_t'(pixel_in * hcpc_pkg::DEC_MULT) : pixel_in;
    end
  end

  assign chain_valid[0] = pre_valid;
  assign chain_px[0]    = pre_px;

  // cell k runs generation k; cells beyond the count pass the pixel through unchanged
  for (genvar k = 0; k < NCELL; k++) begin : g_cell
    hcpc_pkg::cell_ctl_t ctl;
    assign ctl.advance = advance;
    assign ctl.active  = int'(generations) > k;

    hcpc_cell u_cell (
      .clk       (clk),
      .rst       (rst),
      .ctl       (ctl),
      .rules     (rule_codes),
      .valid_in  (chain_valid[k]),
      .px_in     (chain_px[k]),
      .valid_out (chain_valid[k+1]),
      .px_out    (chain_px[k+1])
    );
  end

  // encrypt scales after the automaton
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid_r <= 1'b0;
    end else if (advance) begin
      out_valid_r <= chain_valid[NCELL];
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      pixel_out_r <= decrypt_mode ? chain_px[NCELL]
                                  : hcpc_pkg::pixel_t'(chain_px[NCELL] * hcpc_pkg::ENC_MULT);
    end
  end

  assign out_valid = out_valid_r;
  assign pixel_out = pixel_out_r;

endmodule
